// ----- rtl/pem_pkg.sv -----
// Shared types, constants and codes of the Prewitt edge magnitude block.
package pem_pkg;

	localparam int DIM_W         = 13;
	localparam int POS_W         = 12;
	localparam int CH_W          = 8;
	localparam int NUM_CH        = 3;
	localparam int PIX_W         = CH_W * NUM_CH;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MIN_DIM       = 3;
	localparam int WIDTH_RST     = 640;
	localparam int HEIGHT_RST    = 480;
	localparam int MAG_SAT       = 255;

	localparam int GRAD_W = 10;
	localparam int SQ_W   = 2 * GRAD_W;
	localparam int ACC_W  = SQ_W + 1;
	localparam int ROOT_W = 17;
	localparam int STEP_W = 3;

	localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(2 * NUM_CH - 1);
	localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(CH_W - 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	typedef struct packed {
		logic [CH_W-1:0] pix_red;
		logic [CH_W-1:0] pix_green;
		logic [CH_W-1:0] pix_blue;
	} pix_t;

	typedef struct packed {
		logic [POS_W-1:0] out_col;
		logic [POS_W-1:0] out_row;
		logic [CH_W-1:0]  mag_blue;
		logic [CH_W-1:0]  mag_green;
		logic [CH_W-1:0]  mag_red;
		logic             frame_end;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_GRAD,
		ST_SQ,
		ST_RINIT,
		ST_ROOT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              accept;
		logic              update;
		logic              grad;
		logic              square;
		logic              root_init;
		logic              root_step;
		logic              load_out;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/pem_stream_if.sv -----
// Valid/ready stream channel carrying one word of payload type T.
interface pem_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/prewitt_edge_magnitude_rgb.sv -----
// Top level of the Prewitt edge magnitude block on an RGB pixel stream.
// Border pixel: line store read at acceptance, then update, then the next word is taken.
// Interior pixel: update, gradients, the shared squarer (6 steps) and the bit-serial square root
// (8 steps) run in turn; the result loads once the output is free, then a new pixel is taken.
// The next pixel is taken while a result word still waits at the output.
// Reset: 640x480 geometry, counters and window cleared; line stores keep their contents.
module prewitt_edge_magnitude_rgb
	import pem_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pem_stream_if.sink           pixel,
	pem_stream_if.source         result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [DIM_W-1:0]     cfg_wdata
);

	cmd_t cmd;
	sts_t sts;
	pix_t in_word;
	res_t out_word;

	assign in_word = pixel.data;

	pem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_ready (pixel.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pem_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_word),
		.out_data  (out_word),
		.out_valid (result.valid),
		.out_ready (result.ready)
	);

	assign result.data = out_word;

endmodule

// ----- rtl/pem_ctrl.sv -----
// Sequencer for the Prewitt edge magnitude block.
module pem_ctrl
	import pem_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_GRAD:  step_q <= '0;
				ST_SQ:    step_q <= step_q + STEP_W'(1);
				ST_RINIT: step_q <= ROOT_LAST;
				ST_ROOT:  step_q <= step_q - STEP_W'(1);
				default:  step_q <= step_q;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_UPD;
			ST_UPD:   state_d = sts.emit ? ST_GRAD : ST_IDLE;
			ST_GRAD:  state_d = ST_SQ;
			ST_SQ:    if (step_q == SQ_LAST) state_d = ST_RINIT;
			ST_RINIT: state_d = ST_ROOT;
			ST_ROOT:  if (step_q == '0) state_d = ST_EMIT;
			ST_EMIT:  if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.step = step_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_UPD:   cmd.update    = 1'b1;
			ST_GRAD:  cmd.grad      = 1'b1;
			ST_SQ:    cmd.square    = 1'b1;
			ST_RINIT: cmd.root_init = 1'b1;
			ST_ROOT:  cmd.root_step = 1'b1;
			ST_EMIT:  cmd.load_out  = sts.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

// ----- rtl/pem_dp.sv -----
// Datapath: line stores, window, counters, gradients, squarer, root lanes, output word.
module pem_dp
	import pem_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [DIM_W-1:0]     cfg_wdata,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  pix_t                 in_data,
	output res_t                 out_data,
	output logic                 out_valid,
	input  logic                 out_ready
);

	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [POS_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] col_inc, row_inc;

	logic [PIX_W-1:0]  older_mem [MAX_WIDTH];
	logic [PIX_W-1:0]  newer_mem [MAX_WIDTH];
	logic [ADDR_W-1:0] rd_addr, addr_q;
	logic [PIX_W-1:0]  top_rd_q, mid_rd_q, pix_q;

	logic [2:0][2:0][PIX_W-1:0] win_q;

	logic [POS_W-1:0] tag_col_q, tag_row_q;
	logic             tag_end_q;

	logic [GRAD_W-1:0] gh_abs [NUM_CH];
	logic [GRAD_W-1:0] gv_abs [NUM_CH];
	logic [GRAD_W-1:0] gh_q   [NUM_CH];
	logic [GRAD_W-1:0] gv_q   [NUM_CH];
	logic [ACC_W-1:0]  acc_q  [NUM_CH];
	logic [1:0]        lane;
	logic [GRAD_W-1:0] sq_op;
	logic [SQ_W-1:0]   prod;

	logic [ROOT_W-1:0] rem_q  [NUM_CH];
	logic [ROOT_W-1:0] root_q [NUM_CH];
	logic              sat_q  [NUM_CH];
	logic [ROOT_W-1:0] rem_d  [NUM_CH];
	logic [ROOT_W-1:0] root_d [NUM_CH];
	logic [CH_W-1:0]   mag    [NUM_CH];

	res_t out_q;
	logic out_valid_q;

	always_comb begin
		if (width_q < DIM_W'(MIN_DIM))
			w_eff = DIM_W'(MIN_DIM);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q < DIM_W'(MIN_DIM))
			h_eff = DIM_W'(MIN_DIM);
		else if (32'(height_q) > MAX_HEIGHT)
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	assign col_inc = {1'b0, col_q} + DIM_W'(1);
	assign row_inc = {1'b0, row_q} + DIM_W'(1);
	assign rd_addr = (32'(col_q) < MAX_WIDTH) ? ADDR_W'(col_q) : ADDR_W'(MAX_WIDTH - 1);

	assign sts.emit     = (col_q >= POS_W'(2)) && (row_q >= POS_W'(2));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(WIDTH_RST);
			height_q <= DIM_W'(HEIGHT_RST);
			col_q    <= '0;
			row_q    <= '0;
			win_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.update) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top_rd_q;
			win_q[1][2] <= mid_rd_q;
			win_q[2][2] <= pix_q;
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
			end else begin
				col_q <= col_inc[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			top_rd_q <= older_mem[rd_addr];
			mid_rd_q <= newer_mem[rd_addr];
			addr_q   <= rd_addr;
			pix_q    <= in_data;
		end
		if (cmd.update) begin
			older_mem[addr_q] <= mid_rd_q;
			newer_mem[addr_q] <= pix_q;
			tag_col_q         <= col_q - POS_W'(1);
			tag_row_q         <= row_q - POS_W'(1);
			tag_end_q         <= (col_inc == w_eff) && (row_inc == h_eff);
		end
	end

	always_comb begin
		logic [GRAD_W-1:0] t_sum, b_sum, l_sum, r_sum;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			t_sum = GRAD_W'(win_q[0][0][ch*CH_W +: CH_W]) + GRAD_W'(win_q[0][1][ch*CH_W +: CH_W])
			      + GRAD_W'(win_q[0][2][ch*CH_W +: CH_W]);
			b_sum = GRAD_W'(win_q[2][0][ch*CH_W +: CH_W]) + GRAD_W'(win_q[2][1][ch*CH_W +: CH_W])
			      + GRAD_W'(win_q[2][2][ch*CH_W +: CH_W]);
			l_sum = GRAD_W'(win_q[0][0][ch*CH_W +: CH_W]) + GRAD_W'(win_q[1][0][ch*CH_W +: CH_W])
			      + GRAD_W'(win_q[2][0][ch*CH_W +: CH_W]);
			r_sum = GRAD_W'(win_q[0][2][ch*CH_W +: CH_W]) + GRAD_W'(win_q[1][2][ch*CH_W +: CH_W])
			      + GRAD_W'(win_q[2][2][ch*CH_W +: CH_W]);
			gh_abs[ch] = (t_sum >= b_sum) ? t_sum - b_sum : b_sum - t_sum;
			gv_abs[ch] = (l_sum >= r_sum) ? l_sum - r_sum : r_sum - l_sum;
		end
	end

	assign lane = cmd.step[2:1];

	always_comb begin
		sq_op = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (lane == 2'(ch))
				sq_op = cmd.step[0] ? gv_q[ch] : gh_q[ch];
		end
	end

	assign prod = SQ_W'(sq_op) * SQ_W'(sq_op);

	always_comb begin
		logic [ROOT_W-1:0] bit_v, trial;
		bit_v = ROOT_W'(1) << {cmd.step, 1'b0};
		for (int ch = 0; ch < NUM_CH; ch++) begin
			trial = root_q[ch] + bit_v;
			if (rem_q[ch] >= trial) begin
				rem_d[ch]  = rem_q[ch] - trial;
				root_d[ch] = (root_q[ch] >> 1) + bit_v;
			end else begin
				rem_d[ch]  = rem_q[ch];
				root_d[ch] = root_q[ch] >> 1;
			end
			mag[ch] = sat_q[ch] ? CH_W'(MAG_SAT) : root_q[ch][CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			if (cmd.grad) begin
				gh_q[ch]  <= gh_abs[ch];
				gv_q[ch]  <= gv_abs[ch];
				acc_q[ch] <= '0;
			end
			if (cmd.square && (lane == 2'(ch)))
				acc_q[ch] <= acc_q[ch] + ACC_W'(prod);
			if (cmd.root_init) begin
				sat_q[ch]  <= (acc_q[ch][ACC_W-1:16] != '0);
				rem_q[ch]  <= ROOT_W'(acc_q[ch][15:0]);
				root_q[ch] <= '0;
			end
			if (cmd.root_step) begin
				rem_q[ch]  <= rem_d[ch];
				root_q[ch] <= root_d[ch];
			end
		end
		if (cmd.load_out) begin
			out_q.out_col   <= tag_col_q;
			out_q.out_row   <= tag_row_q;
			out_q.mag_blue  <= mag[0];
			out_q.mag_green <= mag[1];
			out_q.mag_red   <= mag[2];
			out_q.frame_end <= tag_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule
